@@ hdl/bitmap_slot_allocator_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
// Expects signals clk and arst_n in the including scope.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap_slot_allocator assertion failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap_slot_allocator assertion failed");

`endif

@@ hdl/bsa_pkg.sv @@
// Shared constants, types and op codes for the bitmap slot allocator.
// No dependencies.
`default_nettype none
package bsa_pkg;
	localparam int NUM_SLOTS = 64;
	localparam int ACT_W     = 7;   // active_size register width
	localparam int IDX_W     = 6;   // slot_index / position field width
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W     = (CNT_W > ACT_W) ? CNT_W : ACT_W;
	localparam int WORD_W    = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
	localparam int WORD_BW   = $clog2(WORD_W);
	localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	typedef enum logic [2:0] {
		FN_ALLOC      = 3'd0,
		FN_TAKE       = 3'd1,
		FN_FIRST_CLR  = 3'd2,
		FN_NEXT_CLR   = 3'd3,
		FN_FIRST_SET  = 3'd4,
		FN_NEXT_SET   = 3'd5,
		FN_COUNT      = 3'd6,
		FN_WRITE      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               hit;
		logic [WORD_BW-1:0] bit_pos;
		logic [WORD_BW:0]   ones;
	} scan_res_t;
endpackage
`default_nettype wire

@@ hdl/bsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/bsa_word_scan.sv @@
// Scans one bitmap word: lowest matching slot inside [start, lim) and busy count.
// Uses bsa_pkg.
`default_nettype none
module bsa_word_scan
	import bsa_pkg::*;
(
	input  wire logic [WORD_W-1:0] word,
	input  wire logic [CMP_W-1:0]  base,
	input  wire logic [CMP_W-1:0]  start,
	input  wire logic [CMP_W-1:0]  lim,
	input  wire logic              want,
	output scan_res_t              res
);
	logic [WORD_W-1:0] in_rng;
	logic [WORD_W-1:0] cand;
	logic [CMP_W-1:0]  slot_num;

	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			slot_num  = base + CMP_W'(b);
			in_rng[b] = (slot_num >= start) && (slot_num < lim);
		end
		cand = (want ? word : ~word) & in_rng;
	end

	always_comb begin
		res = '0;
		// high to low so the lowest candidate wins
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				res.hit     = 1'b1;
				res.bit_pos = WORD_BW'(b);
			end
		end
		for (int b = 0; b < WORD_W; b++) begin
			res.ones = res.ones + (WORD_BW + 1)'(word[b] & in_rng[b]);
		end
	end
endmodule
`default_nettype wire

@@ hdl/bitmap_slot_allocator.sv @@
// Top level of the bitmap slot allocator: sequencer around the bitmap RAM.
// Uses bsa_pkg, bsa_ram, bsa_word_scan and bitmap_slot_allocator_assert.svh.
//
// Usage:
//   Request channel (in_valid/in_ready) carries func, slot_index, write_value.
//   Result channel (out_valid/out_ready) returns found, position, set_count,
//   one result word per request word, in order.
//   cfg_we/cfg_wdata write active_size; write it only while the block is idle.
// Timing:
//   The bitmap sits in a RAM of 32-bit words (2 words for 64 slots). Each word
//   visited passes through a read state and an evaluate state. After the last
//   word the result is registered and, unless the output stalls, the sequencer
//   returns to idle to take the next request. A request visits 1 or 2 words.
//   A write visits one word, searches stop at the hit or at the active size, count
//   visits all words below the active size. Read-modify-writes finish in ST_EV.
//   A new request is taken while the previous result waits in the output register.
// Reset: all slots free (per-word valid flags cleared, no RAM sweep needed),
//   active_size = 64, both channels empty.
// Stall: if out_ready is low the finished result is held in a side register
//   and no new request is taken until the output register drains.
`default_nettype none
`include "bitmap_slot_allocator_assert.svh"
module bitmap_slot_allocator
	import bsa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       func,
	input  wire logic [IDX_W-1:0] slot_index,
	input  wire logic             write_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  found,
	output logic [IDX_W-1:0]      position,
	output logic [ACT_W-1:0]      set_count,
	input  wire logic             cfg_we,
	input  wire logic [ACT_W-1:0] cfg_wdata
);
	state_t state_q, state_d;

	logic [ACT_W-1:0]   active_size_q;
	func_t              op_q;
	logic [IDX_W-1:0]   idx_q;
	logic               wv_q;
	logic [WORD_AW-1:0] word_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_WORDS-1:0] wvalid_q;

	logic               res_found_q;
	logic [IDX_W-1:0]   res_pos_q;
	logic [ACT_W-1:0]   res_cnt_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [IDX_W-1:0]   out_pos_q;
	logic [ACT_W-1:0]   out_cnt_q;

	logic [WORD_W-1:0]  ram_rdata;
	logic [WORD_W-1:0]  word_eff;
	logic [WORD_W-1:0]  ram_wdata;
	logic               ram_we;
	logic [CMP_W-1:0]   lim;
	logic [CMP_W-1:0]   start;
	logic [CMP_W-1:0]   base;
	logic [CMP_W:0]     next_base;
	logic               want;
	logic               is_search;
	logic               last_word;
	logic               fin;
	logic               out_free;
	logic               load_out_ev;
	logic               load_out_held;
	logic [WORD_BW-1:0] mod_bit;
	logic               mod_val;
	logic               idx_in_store;
	logic [WORD_AW-1:0] idx_word;
	logic               res_found_d;
	logic [IDX_W-1:0]   res_pos_d;
	logic [ACT_W-1:0]   res_cnt_d;
	logic [CNT_W-1:0]   cnt_sum;
	scan_res_t          sr;

	bsa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(word_q),
		.wdata(ram_wdata),
		.raddr(word_q),
		.rdata(ram_rdata)
	);

	// a word never written reads as all free
	assign word_eff = wvalid_q[word_q] ? ram_rdata : '0;

	always_comb begin
		if (CMP_W'(active_size_q) > CMP_W'(NUM_SLOTS)) begin
			lim = CMP_W'(NUM_SLOTS);
		end else begin
			lim = CMP_W'(active_size_q);
		end
	end

	assign want      = op_q inside {FN_TAKE, FN_FIRST_SET, FN_NEXT_SET};
	assign is_search = !(op_q inside {FN_COUNT, FN_WRITE});
	assign start     = (op_q inside {FN_NEXT_CLR, FN_NEXT_SET}) ?
		CMP_W'(idx_q) + CMP_W'(1) : '0;
	assign base      = CMP_W'(word_q) << WORD_BW;
	assign next_base = (CMP_W + 1)'((CMP_W + 1)'(word_q) + (CMP_W + 1)'(1)) << WORD_BW;
	assign last_word = (word_q == WORD_AW'(NUM_WORDS - 1)) || (next_base >= {1'b0, lim});

	assign idx_word     = WORD_AW'(CMP_W'(idx_q) >> WORD_BW);
	assign idx_in_store = CMP_W'(idx_q) < CMP_W'(NUM_SLOTS);

	bsa_word_scan u_scan (
		.word (word_eff),
		.base (base),
		.start(start),
		.lim  (lim),
		.want (want),
		.res  (sr)
	);

	assign cnt_sum = cnt_q + CNT_W'(sr.ones);

	always_comb begin
		case (op_q)
			FN_WRITE: fin = 1'b1;
			FN_COUNT: fin = last_word;
			default:  fin = sr.hit || last_word;
		endcase
	end

	// read-modify-write of the current word
	always_comb begin
		mod_bit = sr.bit_pos;
		mod_val = (op_q == FN_ALLOC);
		if (op_q == FN_WRITE) begin
			mod_bit = WORD_BW'(idx_q);
			mod_val = wv_q;
		end
		ram_wdata = (word_eff & ~(WORD_W'(1) << mod_bit)) | (WORD_W'(mod_val) << mod_bit);
	end

	always_comb begin
		res_found_d = is_search ? sr.hit : 1'b1;
		res_pos_d   = (is_search && sr.hit) ?
			IDX_W'({word_q, sr.bit_pos}) : '0;
		res_cnt_d   = (op_q == FN_COUNT) ? ACT_W'(cnt_sum) : '0;
	end

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_EV;
			ST_EV: begin
				if (!fin) begin
					state_d = ST_RD;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready      = 1'b0;
		ram_we        = 1'b0;
		load_out_ev   = 1'b0;
		load_out_held = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EV: begin
				case (op_q)
					FN_ALLOC, FN_TAKE: ram_we = sr.hit;
					FN_WRITE:          ram_we = idx_in_store;
					default:           ram_we = 1'b0;
				endcase
				load_out_ev = fin && out_free;
			end
			ST_OUT: load_out_held = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_size_q <= ACT_W'(64);
			wvalid_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				active_size_q <= cfg_wdata;
			end
			if (ram_we) begin
				wvalid_q[word_q] <= 1'b1;
			end
			if (load_out_ev || load_out_held) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= func_t'(func);
			idx_q  <= slot_index;
			wv_q   <= write_value;
			cnt_q  <= '0;
			word_q <= (func_t'(func) == FN_WRITE) ?
				WORD_AW'(CMP_W'(slot_index) >> WORD_BW) : '0;
		end else if (state_q == ST_EV && !fin) begin
			word_q <= word_q + WORD_AW'(1);
			cnt_q  <= cnt_sum;
		end
		if (state_q == ST_EV && fin) begin
			res_found_q <= res_found_d;
			res_pos_q   <= res_pos_d;
			res_cnt_q   <= res_cnt_d;
		end
		if (load_out_ev) begin
			out_found_q <= res_found_d;
			out_pos_q   <= res_pos_d;
			out_cnt_q   <= res_cnt_d;
		end else if (load_out_held) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
			out_cnt_q   <= res_cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign position  = out_pos_q;
	assign set_count = out_cnt_q;

	// a write op only touches the word holding its slot
	`BSA_ASSERT_IMPL(a_write_word, ram_we && op_q == FN_WRITE, word_q == idx_word)
	`BSA_ASSERT_IMPL(a_we_in_eval, ram_we, state_q == ST_EV)
	`BSA_ASSERT_NEXT(a_rd_then_ev, state_q == ST_RD, state_q == ST_EV)
	`BSA_ASSERT_IMPL(a_cnt_bound, out_valid_q, CMP_W'(out_cnt_q) <= CMP_W'(NUM_SLOTS))
	`BSA_ASSERT_IMPL(a_held_pending, state_q == ST_OUT, out_valid_q)
endmodule
`default_nettype wire

@@ test/slot_allocator_monitor.sv @@
`timescale 1ns / 1ps
// Passive monitor for bitmap_slot_allocator: keeps its own slot map and active size,
// predicts each result word and compares it in order. Depends on bsa_pkg.
module slot_allocator_monitor
	import bsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [2:0]       func,
	input  logic [IDX_W-1:0] slot_index,
	input  logic             write_value,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             found,
	input  logic [IDX_W-1:0] position,
	input  logic [ACT_W-1:0] set_count,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               replies_open
);
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] pos;
		logic [ACT_W-1:0] cnt;
	} reply_t;

	logic       busy_map [NUM_SLOTS];
	logic [ACT_W-1:0] act_size;
	reply_t     replies_due [$];

	function automatic int scan_limit();
		return (act_size > NUM_SLOTS) ? NUM_SLOTS : int'(act_size);
	endfunction

	// lowest slot in [first, limit) whose flag equals want
	function automatic logic find_slot(input int first, input logic want, output int slot);
		int lim;
		lim = scan_limit();
		slot = 0;
		for (int i = first; i < lim; i++) begin
			if (busy_map[i] == want) begin
				slot = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic apply_request(input func_t op, input logic [IDX_W-1:0] idx, input logic val,
			output reply_t r);
		int   slot;
		int   tally;
		logic hit;
		hit = 1'b1;
		slot = 0;
		tally = 0;
		case (op)
			FN_ALLOC: begin
				hit = find_slot(0, 1'b0, slot);
				if (hit)
					busy_map[slot] = 1'b1;
			end
			FN_TAKE: begin
				hit = find_slot(0, 1'b1, slot);
				if (hit)
					busy_map[slot] = 1'b0;
			end
			FN_FIRST_CLR: hit = find_slot(0, 1'b0, slot);
			FN_NEXT_CLR:  hit = find_slot(int'(idx) + 1, 1'b0, slot);
			FN_FIRST_SET: hit = find_slot(0, 1'b1, slot);
			FN_NEXT_SET:  hit = find_slot(int'(idx) + 1, 1'b1, slot);
			FN_COUNT: begin
				for (int i = 0; i < scan_limit(); i++)
					tally += int'(busy_map[i]);
			end
			default: begin
				// writes ignore the active size
				if (int'(idx) < NUM_SLOTS)
					busy_map[idx] = val;
			end
		endcase
		if (!hit)
			slot = 0;
		r.hit = hit;
		r.pos = slot[IDX_W-1:0];
		r.cnt = tally[ACT_W-1:0];
	endtask

	task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				busy_map[i] = 1'b0;
			act_size = 7'd64;
			replies_due.delete();
			replies_open = 0;
			mismatches = 0;
		end else begin
			// drain side first: a word accepted this edge can't be answered this edge
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t ns: result word with nothing outstanding, expected none, got %0d/%0d/%0d",
						$time, found, position, set_count);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					report("found", 8'(want.hit), 8'(found));
					report("position", 8'(want.pos), 8'(position));
					report("set_count", 8'(want.cnt), 8'(set_count));
				end
			end
			if (in_valid && in_ready) begin
				apply_request(func_t'(func), slot_index, write_value, want);
				replies_due.push_back(want);
			end
			if (cfg_we)
				act_size = cfg_wdata;
			replies_open = replies_due.size();
		end
	end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for bitmap_slot_allocator; result checking lives in
// slot_allocator_monitor. Depends on bsa_pkg and the allocator RTL.
module tb;
	import bsa_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 13;
	localparam int PHASE_WORDS = 100;
	localparam logic [ACT_W-1:0] SIZE_PLAN [PHASES] =
		'{7'd64, 7'd1, 7'd127, 7'd0, 7'd32, 7'd33, 7'd2, 7'd63, 7'd65,
		  7'd0, 7'd0, 7'd0, 7'd64};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [2:0]       func;
	logic [IDX_W-1:0] slot_index;
	logic             write_value;
	logic             out_valid;
	logic             out_ready;
	logic             found;
	logic [IDX_W-1:0] position;
	logic [ACT_W-1:0] set_count;
	logic             cfg_we;
	logic [ACT_W-1:0] cfg_wdata;
	int               mismatches;
	int               replies_open;
	bit               long_hold;
	bit               rx_calm;
	bit               tx_calm;

	always #6 clk = ~clk;

	bitmap_slot_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .slot_index(slot_index), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .position(position), .set_count(set_count),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	slot_allocator_monitor mon (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .slot_index(slot_index), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .position(position), .set_count(set_count),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .replies_open(replies_open)
	);

	// mostly back to back, sometimes a short gap, rarely a long gap
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input func_t op, input logic [IDX_W-1:0] idx, input logic val);
		int gap;
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		slot_index <= idx;
		write_value <= val;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		@(negedge clk);
	endtask

	// wait for every outstanding word, then let the sequencer settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (replies_open != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_size(input logic [ACT_W-1:0] v);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// bias: 1 favors allocate, 2 favors take, else uniform
	task automatic rand_word(input int size, input int bias);
		func_t op;
		int    r;
		int    span;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (bias == 1 && r < 55)
			op = FN_ALLOC;
		else if (bias == 2 && r < 55)
			op = FN_TAKE;
		else
			op = func_t'(3'($urandom_range(0, 7)));
		span = (size < 1) ? 1 : ((size > NUM_SLOTS) ? NUM_SLOTS : size);
		// keep indexes inside the active window half of the time
		if ($urandom_range(0, 1) == 1)
			idx = IDX_W'($urandom_range(0, span - 1));
		else
			idx = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
		send_word(op, idx, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				// long back-pressure so the request side fills and stalls
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_len() + 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int size;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_ALLOC;
		slot_index = '0;
		write_value = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		long_hold = 1'b0;
		rx_calm = 1'b0;
		tx_calm = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty map at full size
		send_word(FN_COUNT, 6'd0, 1'b0);
		send_word(FN_FIRST_SET, 6'd0, 1'b0);
		send_word(FN_TAKE, 6'd0, 1'b0);
		send_word(FN_ALLOC, 6'd0, 1'b0);
		send_word(FN_ALLOC, 6'd63, 1'b1);
		send_word(FN_NEXT_CLR, 6'd63, 1'b0);   // next search from the last slot
		send_word(FN_NEXT_SET, 6'd0, 1'b0);
		send_word(FN_WRITE, 6'd63, 1'b1);
		send_word(FN_NEXT_SET, 6'd62, 1'b0);
		send_word(FN_FIRST_CLR, 6'd0, 1'b0);
		send_word(FN_COUNT, 6'd0, 1'b0);
		send_word(FN_TAKE, 6'd0, 1'b0);
		send_word(FN_FIRST_SET, 6'd0, 1'b0);
		send_word(FN_WRITE, 6'd63, 1'b0);

		// zero active size: nothing searched, writes still land
		set_size(7'd0);
		send_word(FN_ALLOC, 6'd0, 1'b0);
		send_word(FN_FIRST_CLR, 6'd0, 1'b0);
		send_word(FN_COUNT, 6'd0, 1'b0);
		send_word(FN_WRITE, 6'd5, 1'b1);

		// size above the store clamps to the store
		set_size(7'd127);
		send_word(FN_NEXT_CLR, 6'd4, 1'b0);
		send_word(FN_COUNT, 6'd0, 1'b0);

		set_size(7'd1);
		send_word(FN_FIRST_SET, 6'd0, 1'b0);
		send_word(FN_NEXT_CLR, 6'd0, 1'b0);
		send_word(FN_ALLOC, 6'd0, 1'b0);
		send_word(FN_ALLOC, 6'd0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p >= 9 && p <= 11)
				size = $urandom_range(0, 127);
			else
				size = int'(SIZE_PLAN[p]);
			set_size(7'(size));
			tx_calm = (p == 5);
			rx_calm = (p == 5);
			if (p == 2)
				long_hold = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == PHASES - 1 || k < PHASE_WORDS / 2)
					rand_word(size, 1);
				else
					rand_word(size, p % 3);
			end
		end

		quiesce();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
